@@ hdl/bkv_pkg.sv @@
package bkv_pkg;

    // Operation field
    localparam int OP_BITS = 3;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_FIND_V = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FIND_C = 3'd4;

    // Result status field
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd2;

    // Reported pair count width
    localparam int COUNT_BITS = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Decoded command kind
    typedef enum logic [2:0] {
        K_CLEAR,
        K_INSERT,
        K_REMOVE,
        K_FIND_V,
        K_FIND_C,
        K_NOP
    } t_kind;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SH_RD,
        S_SH_WR
    } t_state;

endpackage

@@ hdl/bkv_if.sv @@
interface bkv_in_if #(
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
);
    logic                         valid;
    logic                         ready;
    logic [bkv_pkg::OP_BITS-1:0]  operation;
    logic [VERTEX_BITS-1:0]       vertex;
    logic [CODE_BITS-1:0]         code;

    modport source(output valid, operation, vertex, code, input ready);
    modport sink(input valid, operation, vertex, code, output ready);
endinterface

interface bkv_out_if #(
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
);
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [VERTEX_BITS-1:0]          vertex_out;
    logic [CODE_BITS-1:0]            code_out;
    logic [bkv_pkg::COUNT_BITS-1:0]  entry_count;
    logic [bkv_pkg::STATUS_BITS-1:0] status;

    modport source(output valid, found, vertex_out, code_out, entry_count, status,
                   input ready);
    modport sink(input valid, found, vertex_out, code_out, entry_count, status,
                 output ready);
endinterface

@@ hdl/bkv_ram.sv @@
module bkv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bkv_front.sv @@
module bkv_front #(
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bkv_pkg::OP_BITS-1:0] i_operation,
    input  logic [VERTEX_BITS-1:0]      i_vertex,
    input  logic [CODE_BITS-1:0]        i_code,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output bkv_pkg::t_kind              o_cmd_kind,
    output logic [VERTEX_BITS-1:0]      o_cmd_vertex,
    output logic [CODE_BITS-1:0]        o_cmd_code
);
    import bkv_pkg::*;

    t_kind                  w_kind;
    t_kind                  r_kind   [QUEUE_DEPTH];
    logic [VERTEX_BITS-1:0] r_vertex [QUEUE_DEPTH];
    logic [CODE_BITS-1:0]   r_code   [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wp, n_wp;
    logic [QPTR_BITS-1:0]   r_rp, n_rp;
    logic [QFILL_BITS-1:0]  r_fill, n_fill;
    logic                   w_push;
    logic                   w_pop;

    // Decode the operation code into a command kind
    always_comb begin
        unique case (i_operation)
            OP_CLEAR:  w_kind = K_CLEAR;
            OP_INSERT: w_kind = K_INSERT;
            OP_REMOVE: w_kind = K_REMOVE;
            OP_FIND_V: w_kind = K_FIND_V;
            OP_FIND_C: w_kind = K_FIND_C;
            default:   w_kind = K_NOP;
        endcase
    end

    assign o_ready     = (r_fill != QFILL_BITS'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    assign o_cmd_kind   = r_kind[r_rp];
    assign o_cmd_vertex = r_vertex[r_rp];
    assign o_cmd_code   = r_code[r_rp];

    // Advance queue pointers and fill level
    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_fill = r_fill;
        if (w_push) begin
            n_wp = (r_wp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wp]   <= w_kind;
            r_vertex[r_wp] <= i_vertex;
            r_code[r_wp]   <= i_code;
        end
    end

endmodule

@@ hdl/bkv_back.sv @@
module bkv_back #(
    parameter int DEPTH       = 64,
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  bkv_pkg::t_kind                  i_cmd_kind,
    input  logic [VERTEX_BITS-1:0]          i_cmd_vertex,
    input  logic [CODE_BITS-1:0]            i_cmd_code,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic                            o_found,
    output logic [VERTEX_BITS-1:0]          o_vertex_out,
    output logic [CODE_BITS-1:0]            o_code_out,
    output logic [bkv_pkg::COUNT_BITS-1:0]  o_entry_count,
    output logic [bkv_pkg::STATUS_BITS-1:0] o_status
);
    import bkv_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = VERTEX_BITS + CODE_BITS;

    t_state                 r_state, n_state;
    t_kind                  r_kind, n_kind;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [VERTEX_BITS-1:0] r_key_v, n_key_v;
    logic [CODE_BITS-1:0]   r_key_c, n_key_c;

    logic                   r_out_valid, n_out_valid;
    logic                   r_found, n_found;
    logic [VERTEX_BITS-1:0] r_vout, n_vout;
    logic [CODE_BITS-1:0]   r_cout, n_cout;
    logic [COUNT_BITS-1:0]  r_ecount, n_ecount;
    logic [STATUS_BITS-1:0] r_status, n_status;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [DATA_W-1:0]      w_wdata;
    logic [IDX_W-1:0]       w_raddr;
    logic [DATA_W-1:0]      w_rdata;
    logic [VERTEX_BITS-1:0] w_rd_v;
    logic [CODE_BITS-1:0]   w_rd_c;
    logic                   w_match;
    logic [CNT_W:0]         w_idx1;
    logic [CNT_W:0]         w_idx2;
    logic [CNT_W:0]         w_cnt_w;

    logic                   w_emit;
    logic                   w_e_found;
    logic [VERTEX_BITS-1:0] w_e_vout;
    logic [CODE_BITS-1:0]   w_e_cout;
    logic [STATUS_BITS-1:0] w_e_status;
    logic [CNT_W+COUNT_BITS-1:0] w_cnt_ext;

    // Pair store, oldest at address 0, newest at count-1
    bkv_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_v  = w_rdata[DATA_W-1:CODE_BITS];
    assign w_rd_c  = w_rdata[CODE_BITS-1:0];
    assign w_match = (r_kind == K_FIND_C) ? (w_rd_c == r_key_c) : (w_rd_v == r_key_v);
    assign w_idx1  = (CNT_W + 1)'(r_idx) + 1'b1;
    assign w_idx2  = (CNT_W + 1)'(r_idx) + 2'd2;
    assign w_cnt_w = {1'b0, r_count};

    // Sequence one command and build its result
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key_v     = r_key_v;
        n_key_c     = r_key_c;
        n_out_valid = r_out_valid && !i_res_ready;
        n_found     = r_found;
        n_vout      = r_vout;
        n_cout      = r_cout;
        n_ecount    = r_ecount;
        n_status    = r_status;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_rdata;
        w_raddr     = r_idx;
        w_emit      = 1'b0;
        w_e_found   = 1'b0;
        w_e_vout    = '0;
        w_e_cout    = '0;
        w_e_status  = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = !r_out_valid;
                if (i_cmd_valid && !r_out_valid) begin
                    n_kind  = i_cmd_kind;
                    n_key_v = i_cmd_vertex;
                    n_key_c = i_cmd_code;
                    case (i_cmd_kind) inside
                        K_CLEAR: begin
                            n_count = '0;
                            w_emit  = 1'b1;
                        end
                        K_INSERT: begin
                            w_emit = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                w_e_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[IDX_W-1:0];
                                w_wdata = {i_cmd_vertex, i_cmd_code};
                                n_count = r_count + 1'b1;
                            end
                        end
                        K_REMOVE, K_FIND_V, K_FIND_C: begin
                            if (r_count == '0) begin
                                w_emit     = 1'b1;
                                w_e_status = (i_cmd_kind == K_REMOVE) ? ST_MISS : ST_OK;
                            end else begin
                                n_idx   = IDX_W'(r_count - 1'b1);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end

            // Fetch the next candidate, newest first
            S_READ: begin
                w_raddr = r_idx;
                n_state = S_CMP;
            end

            S_CMP: begin
                if (w_match) begin
                    if (r_kind == K_REMOVE) begin
                        if (w_idx1 < w_cnt_w) begin
                            n_state = S_SH_RD;
                        end else begin
                            n_count   = r_count - 1'b1;
                            w_emit    = 1'b1;
                            w_e_found = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        w_emit    = 1'b1;
                        w_e_found = 1'b1;
                        if (r_kind == K_FIND_C) begin
                            w_e_vout = w_rd_v;
                        end else begin
                            w_e_cout = w_rd_c;
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_idx == '0) begin
                    w_emit     = 1'b1;
                    w_e_status = (r_kind == K_REMOVE) ? ST_MISS : ST_OK;
                    n_state    = S_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_READ;
                end
            end

            // Close the gap: move each newer pair down one address
            S_SH_RD: begin
                w_raddr = w_idx1[IDX_W-1:0];
                n_state = S_SH_WR;
            end

            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = w_idx1[IDX_W-1:0];
                if (w_idx2 < w_cnt_w) begin
                    n_state = S_SH_RD;
                end else begin
                    n_count   = r_count - 1'b1;
                    w_emit    = 1'b1;
                    w_e_found = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register
        w_cnt_ext = {{COUNT_BITS{1'b0}}, n_count};
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_found     = w_e_found;
            n_vout      = w_e_vout;
            n_cout      = w_e_cout;
            n_status    = w_e_status;
            n_ecount    = w_cnt_ext[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_idx    <= n_idx;
        r_key_v  <= n_key_v;
        r_key_c  <= n_key_c;
        r_found  <= n_found;
        r_vout   <= n_vout;
        r_cout   <= n_cout;
        r_ecount <= n_ecount;
        r_status <= n_status;
    end

    assign o_res_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_vertex_out  = r_vout;
    assign o_code_out    = r_cout;
    assign o_entry_count = r_ecount;
    assign o_status      = r_status;

endmodule

@@ hdl/bidirectional_key_value_table_top.sv @@
// Table of up to DEPTH (vertex, code) pairs, searched newest first. Each input word
// carries clear, insert, remove-by-vertex, find-by-vertex or find-by-code and yields
// exactly one result word with the pair count. The pairs live in a single-port-write,
// registered-read RAM; a two-word command queue lets the input side keep accepting
// while the table engine works or a result waits. Clear, insert and undefined codes
// finish in the idle state, but the engine starts its next command only after the
// result word has left. A lookup or remove reads the RAM newest first, one pair at a
// time (address in S_READ, then compare in S_CMP), and a remove hit then moves each
// newer pair down one address (read in S_SH_RD, write in S_SH_WR) to close the gap.
// The RAM needs no clearing pass after reset.
module bidirectional_key_value_table_top #(
    parameter int DEPTH       = 64,
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bkv_in_if.sink   i_in,
    bkv_out_if.source o_out
);
    import bkv_pkg::*;

    logic                   w_cmd_valid;
    logic                   w_cmd_ready;
    t_kind                  w_cmd_kind;
    logic [VERTEX_BITS-1:0] w_cmd_vertex;
    logic [CODE_BITS-1:0]   w_cmd_code;

    // Accept and decode input words
    bkv_front #(
        .VERTEX_BITS(VERTEX_BITS),
        .CODE_BITS  (CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_operation (i_in.operation),
        .i_vertex    (i_in.vertex),
        .i_code      (i_in.code),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd_kind  (w_cmd_kind),
        .o_cmd_vertex(w_cmd_vertex),
        .o_cmd_code  (w_cmd_code)
    );

    // Execute commands against the table
    bkv_back #(
        .DEPTH      (DEPTH),
        .VERTEX_BITS(VERTEX_BITS),
        .CODE_BITS  (CODE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd_kind   (w_cmd_kind),
        .i_cmd_vertex (w_cmd_vertex),
        .i_cmd_code   (w_cmd_code),
        .o_res_valid  (o_out.valid),
        .i_res_ready  (o_out.ready),
        .o_found      (o_out.found),
        .o_vertex_out (o_out.vertex_out),
        .o_code_out   (o_out.code_out),
        .o_entry_count(o_out.entry_count),
        .o_status     (o_out.status)
    );

endmodule

@@ sim/bkv_table_checker.sv @@
module bkv_table_checker
    import bkv_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VERTEX_BITS = 8,
    parameter int CODE_BITS   = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bkv_in_if    i_cmd_mon,
    bkv_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   found;
        logic [VERTEX_BITS-1:0] vertex_out;
        logic [CODE_BITS-1:0]   code_out;
        logic [COUNT_BITS-1:0]  entry_count;
        logic [STATUS_BITS-1:0] status;
    } table_reply_t;

    // Shadow table, newest pair in slot 0
    logic [VERTEX_BITS-1:0] held_vertex [DEPTH];
    logic [CODE_BITS-1:0]   held_code   [DEPTH];
    int                     held_pairs = 0;

    table_reply_t predicted_replies [$];
    table_reply_t want;
    table_reply_t got;
    int           fail_count   = 0;
    int           reports_made = 0;
    int           replies_seen = 0;

    // Find the newest held pair whose vertex (or code) matches; -1 on a miss
    function automatic int newest_match(input bit by_code,
                                        input logic [VERTEX_BITS-1:0] v,
                                        input logic [CODE_BITS-1:0] c);
        for (int i = 0; i < held_pairs; i++) begin
            if (by_code ? (held_code[i] == c) : (held_vertex[i] == v))
                return i;
        end
        return -1;
    endfunction

    // Apply one table command to the shadow table and return its reply word
    function automatic table_reply_t apply_command(input logic [OP_BITS-1:0] op,
                                                   input logic [VERTEX_BITS-1:0] v,
                                                   input logic [CODE_BITS-1:0] c);
        table_reply_t r;
        int           hit;
        r = '0;
        case (op)
            OP_CLEAR: begin
                held_pairs = 0;
            end
            OP_INSERT: begin
                if (held_pairs >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Push every held pair down one slot, new pair at the head
                    for (int i = held_pairs; i > 0; i--) begin
                        held_vertex[i] = held_vertex[i-1];
                        held_code[i]   = held_code[i-1];
                    end
                    held_vertex[0] = v;
                    held_code[0]   = c;
                    held_pairs++;
                end
            end
            OP_REMOVE: begin
                hit = newest_match(1'b0, v, c);
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    // Close the gap left by the removed pair
                    r.found = 1'b1;
                    for (int i = hit; i < held_pairs - 1; i++) begin
                        held_vertex[i] = held_vertex[i+1];
                        held_code[i]   = held_code[i+1];
                    end
                    held_pairs--;
                end
            end
            OP_FIND_V: begin
                hit = newest_match(1'b0, v, c);
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.code_out = held_code[hit];
                end
            end
            OP_FIND_C: begin
                hit = newest_match(1'b1, v, c);
                if (hit >= 0) begin
                    r.found      = 1'b1;
                    r.vertex_out = held_vertex[hit];
                end
            end
            default: begin
            end
        endcase
        r.entry_count = COUNT_BITS'(held_pairs);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_pairs = 0;
            predicted_replies.delete();
        end else begin
            // Predict on every accepted command word
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                predicted_replies.push_back(apply_command(i_cmd_mon.operation,
                                                          i_cmd_mon.vertex,
                                                          i_cmd_mon.code));

            // Compare every accepted reply word with the oldest prediction
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.found       = i_res_mon.found;
                got.vertex_out  = i_res_mon.vertex_out;
                got.code_out    = i_res_mon.code_out;
                got.entry_count = i_res_mon.entry_count;
                got.status      = i_res_mon.status;
                if (predicted_replies.size() == 0) begin
                    fail_count++;
                    if (reports_made < REPORT_LIMIT) begin
                        reports_made++;
                        $display("reply %0d: word with no command pending", replies_seen);
                    end
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.found !== want.found || got.vertex_out !== want.vertex_out ||
                        got.code_out !== want.code_out ||
                        got.entry_count !== want.entry_count ||
                        got.status !== want.status) begin
                        fail_count++;
                        if (reports_made < REPORT_LIMIT) begin
                            reports_made++;
                            $display("reply %0d: expected found=%0b vertex=%0h code=%0h",
                                     replies_seen, want.found, want.vertex_out,
                                     want.code_out, " count=%0d status=%0d",
                                     want.entry_count, want.status);
                            $display("reply %0d: got      found=%0b vertex=%0h code=%0h",
                                     replies_seen, got.found, got.vertex_out,
                                     got.code_out, " count=%0d status=%0d",
                                     got.entry_count, got.status);
                        end
                    end
                end
                replies_seen++;
            end
        end
        o_fail_count  = fail_count;
        o_outstanding = predicted_replies.size();
    end

endmodule

@@ sim/tb_bidirectional_key_value_table_top.sv @@
module tb_bidirectional_key_value_table_top;
    import bkv_pkg::*;

    localparam int DEPTH           = 64;
    localparam int VERTEX_BITS     = 8;
    localparam int CODE_BITS       = 8;
    localparam int TOTAL_WORDS     = 1650;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 2_000_000;

    // Operation codes the table treats as no-ops
    localparam logic [OP_BITS-1:0] OP_UNUSED_FIRST = OP_FIND_C + 1'b1;
    localparam logic [OP_BITS-1:0] OP_UNUSED_LAST  = '1;

    logic        i_clk;
    logic        i_rst_n;
    bit          steady_flow     = 1'b0;
    int          words_sent      = 0;
    int          hold_off_asked  = 0;
    int          hold_off_served = 0;
    int          cycle_count     = 0;
    int          fail_count;
    int          outstanding;
    logic [31:0] vertex_mask     = '0;
    logic [31:0] code_mask       = '0;

    bkv_in_if  #(.VERTEX_BITS(VERTEX_BITS), .CODE_BITS(CODE_BITS)) cmd_ch ();
    bkv_out_if #(.VERTEX_BITS(VERTEX_BITS), .CODE_BITS(CODE_BITS)) res_ch ();

    bidirectional_key_value_table_top #(
        .DEPTH      (DEPTH),
        .VERTEX_BITS(VERTEX_BITS),
        .CODE_BITS  (CODE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    bkv_table_checker #(
        .DEPTH      (DEPTH),
        .VERTEX_BITS(VERTEX_BITS),
        .CODE_BITS  (CODE_BITS)
    ) table_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Keys cluster around a per-burst base so lookups and removes hit often
    function automatic logic [31:0] pick_key(input logic [31:0] mask);
        if ($urandom_range(0, 9) < 7)
            return mask ^ $urandom_range(0, 7);
        return $urandom;
    endfunction

    function automatic logic [OP_BITS-1:0] pick_operation();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)  return OP_CLEAR;
        if (roll < 38) return OP_INSERT;
        if (roll < 58) return OP_REMOVE;
        if (roll < 77) return OP_FIND_V;
        if (roll < 95) return OP_FIND_C;
        return OP_BITS'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    // Offer one command word and hold it until accepted
    task automatic send_word(input logic [OP_BITS-1:0]     op,
                             input logic [VERTEX_BITS-1:0] v,
                             input logic [CODE_BITS-1:0]   c);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.vertex    <= v;
        cmd_ch.code      <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_mixed(input int count);
        repeat (count)
            send_word(pick_operation(), VERTEX_BITS'(pick_key(vertex_mask)),
                      CODE_BITS'(pick_key(code_mask)));
    endtask

    // Reply side: random stalls per word, plus requested long hold-offs
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_asked > hold_off_served) begin
                hold_off_served++;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = steady_flow ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Command side: reset, directed words, random bursts, drain
    initial begin
        int burst;
        int kind;
        burst = 0;
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_CLEAR;
        cmd_ch.vertex    <= '0;
        cmd_ch.code      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Misses on an empty table, clear, and the unused codes
        send_word(OP_FIND_V, '0, '0);
        send_word(OP_FIND_C, '1, '1);
        send_word(OP_REMOVE, '1, '0);
        send_word(OP_CLEAR, '1, '1);
        send_word(OP_UNUSED_FIRST, '1, '1);
        send_word(OP_UNUSED_LAST - 1'b1, '0, '1);
        send_word(OP_UNUSED_LAST, '0, '0);

        // Field extremes, duplicate vertex and duplicate code
        send_word(OP_INSERT, '0, '1);
        send_word(OP_INSERT, '1, '0);
        send_word(OP_INSERT, 8'h5a, 8'ha5);
        send_word(OP_INSERT, '0, 8'h3c);
        send_word(OP_INSERT, 8'h77, 8'ha5);
        send_word(OP_FIND_V, '0, '0);
        send_word(OP_FIND_C, '0, 8'ha5);
        send_word(OP_FIND_C, '0, '0);
        send_word(OP_FIND_V, 8'h12, '0);

        // Remove the newest duplicate, then a middle pair
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_FIND_V, '0, '0);
        send_word(OP_REMOVE, 8'h5a, '0);
        send_word(OP_UNUSED_LAST, '1, '1);
        send_word(OP_CLEAR, '0, '0);
        send_word(OP_FIND_C, '0, '0);

        // Random bursts; burst 1 always fills the table past full
        while (words_sent < TOTAL_WORDS) begin
            steady_flow = ($urandom_range(0, 4) == 0);
            vertex_mask = $urandom;
            code_mask   = $urandom;
            kind        = (burst == 1) ? 0 : $urandom_range(0, 9);
            if (burst == 1 || burst == 40)
                hold_off_asked++;
            if (kind == 0) begin
                repeat (DEPTH + 3)
                    send_word(OP_INSERT, VERTEX_BITS'(pick_key(vertex_mask)),
                              CODE_BITS'(pick_key(code_mask)));
                send_mixed(12);
            end else if (kind == 1) begin
                send_word(OP_CLEAR, VERTEX_BITS'($urandom), CODE_BITS'($urandom));
                send_mixed($urandom_range(5, 20));
            end else begin
                send_mixed($urandom_range(10, 30));
            end
            burst++;
        end

        // Drain: wait for every predicted reply, then watch for stray words
        cmd_ch.valid <= 1'b0;
        steady_flow = 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/bkv_pkg.sv
hdl/bkv_if.sv
hdl/bkv_ram.sv
hdl/bkv_front.sv
hdl/bkv_back.sv
hdl/bidirectional_key_value_table_top.sv
sim/bkv_table_checker.sv
sim/tb_bidirectional_key_value_table_top.sv
